### rtl/assert_macros.svh
// assertion helpers for the fft power block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FFTP_ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
    else $error("fft power assertion failed");

`define FFTP_ASSERT(lbl, prop) `FFTP_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

### rtl/fftp_pkg.sv
`default_nettype none
package fftp_pkg;

  localparam int unsigned LogPointsDef = 6;
  localparam int unsigned AddrW        = 6;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned DataW        = 24;
  localparam int unsigned WordW        = 2 * DataW;
  localparam int unsigned PowerW       = 48;
  localparam int unsigned TwW          = 16;
  localparam int unsigned RomIdxW      = 5;
  localparam int unsigned ProdW        = DataW + TwW;
  localparam int unsigned RndW         = ProdW + 1 - 15;
  localparam int unsigned SumW         = RndW + 1;

  typedef struct packed {
    logic [AddrW-1:0]          addr;
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } qent_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [WordW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  function automatic logic [DataW-1:0] sat24(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(8388607);
    lo = -SumW'(8388608);
    if (v > hi) return 24'h7fffff;
    else if (v < lo) return 24'h800000;
    else return v[DataW-1:0];
  endfunction

  function automatic logic [2*TwW-1:0] twiddle(input logic [RomIdxW-1:0] idx);
    logic signed [TwW-1:0] wr;
    logic signed [TwW-1:0] wi;
    case (idx)
      5'd0:  begin wr =  16'sd32767; wi =  16'sd0;     end
      5'd1:  begin wr =  16'sd32610; wi = -16'sd3212;  end
      5'd2:  begin wr =  16'sd32138; wi = -16'sd6393;  end
      5'd3:  begin wr =  16'sd31357; wi = -16'sd9512;  end
      5'd4:  begin wr =  16'sd30274; wi = -16'sd12540; end
      5'd5:  begin wr =  16'sd28899; wi = -16'sd15447; end
      5'd6:  begin wr =  16'sd27246; wi = -16'sd18205; end
      5'd7:  begin wr =  16'sd25330; wi = -16'sd20788; end
      5'd8:  begin wr =  16'sd23170; wi = -16'sd23170; end
      5'd9:  begin wr =  16'sd20788; wi = -16'sd25330; end
      5'd10: begin wr =  16'sd18205; wi = -16'sd27246; end
      5'd11: begin wr =  16'sd15447; wi = -16'sd28899; end
      5'd12: begin wr =  16'sd12540; wi = -16'sd30274; end
      5'd13: begin wr =  16'sd9512;  wi = -16'sd31357; end
      5'd14: begin wr =  16'sd6393;  wi = -16'sd32138; end
      5'd15: begin wr =  16'sd3212;  wi = -16'sd32610; end
      5'd16: begin wr =  16'sd0;     wi = -16'sd32767; end
      5'd17: begin wr = -16'sd3212;  wi = -16'sd32610; end
      5'd18: begin wr = -16'sd6393;  wi = -16'sd32138; end
      5'd19: begin wr = -16'sd9512;  wi = -16'sd31357; end
      5'd20: begin wr = -16'sd12540; wi = -16'sd30274; end
      5'd21: begin wr = -16'sd15447; wi = -16'sd28899; end
      5'd22: begin wr = -16'sd18205; wi = -16'sd27246; end
      5'd23: begin wr = -16'sd20788; wi = -16'sd25330; end
      5'd24: begin wr = -16'sd23170; wi = -16'sd23170; end
      5'd25: begin wr = -16'sd25330; wi = -16'sd20788; end
      5'd26: begin wr = -16'sd27246; wi = -16'sd18205; end
      5'd27: begin wr = -16'sd28899; wi = -16'sd15447; end
      5'd28: begin wr = -16'sd30274; wi = -16'sd12540; end
      5'd29: begin wr = -16'sd31357; wi = -16'sd9512;  end
      5'd30: begin wr = -16'sd32138; wi = -16'sd6393;  end
      5'd31: begin wr = -16'sd32610; wi = -16'sd3212;  end
      default: begin wr = 16'sd0; wi = 16'sd0; end
    endcase
    return {wr, wi};
  endfunction

endpackage
`default_nettype wire

### rtl/fftp_if.sv
`default_nettype none
interface fftp_sample_if;
  import fftp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface fftp_bin_if;
  import fftp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [AddrW-1:0]         bin_index;
  logic signed [DataW-1:0]  real_part;
  logic signed [DataW-1:0]  imag_part;
  logic [PowerW-1:0]        power;
  logic                     last_bin;
  modport source (output valid, output bin_index, output real_part, output imag_part,
                  output power, output last_bin, input ready);
  modport sink (input valid, input bin_index, input real_part, input imag_part,
                input power, input last_bin, output ready);
endinterface
`default_nettype wire

### rtl/fftp_ram.sv
`default_nettype none
module fftp_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/fftp_front.sv
`default_nettype none
module fftp_front import fftp_pkg::*; #(
  parameter int unsigned LOG_POINTS = LogPointsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  fftp_sample_if.sink   sample_i,
  output logic          push_valid_o,
  output qent_t         push_data_o,
  input  wire logic     push_ready_i
);
  localparam int unsigned Points = 1 << LOG_POINTS;

  logic [LOG_POINTS-1:0] cnt_q, cnt_d, rev;

  always_comb begin
    for (int b = 0; b < LOG_POINTS; b++) rev[b] = cnt_q[LOG_POINTS-1-b];
  end

  assign sample_i.ready      = push_ready_i;
  assign push_valid_o        = sample_i.valid;
  assign push_data_o.addr    = AddrW'(rev);
  assign push_data_o.sample  = sample_i.sample;
  assign push_data_o.last    = (cnt_q == LOG_POINTS'(Points - 1));

  always_comb begin
    cnt_d = cnt_q;
    if (sample_i.valid && push_ready_i) cnt_d = cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
endmodule
`default_nettype wire

### rtl/fftp_queue.sv
`default_nettype none
module fftp_queue import fftp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  input  qent_t      push_data_i,
  output logic       push_ready_o,
  output logic       pop_valid_o,
  output qent_t      pop_data_o,
  input  wire logic  pop_i
);
  qent_t      ent_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = ent_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

### rtl/fftp_back.sv
`default_nettype none
module fftp_back import fftp_pkg::*; #(
  parameter int unsigned LOG_POINTS = LogPointsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  qent_t                  q_data_i,
  output logic                   q_pop_o,
  output ram_req_t               ram_req_o,
  input  wire logic [WordW-1:0]  ram_rdata_i,
  fftp_bin_if.source             result_o
);
  localparam int unsigned Points = 1 << LOG_POINTS;
  localparam int unsigned Half   = Points / 2;
  localparam int unsigned NW     = LOG_POINTS - 1;
  localparam int unsigned SW     = $clog2(LOG_POINTS);

  typedef enum logic [10:0] {
    S_LOAD = 11'b00000000001,
    S_RDB  = 11'b00000000010,
    S_RDA  = 11'b00000000100,
    S_MUL  = 11'b00000001000,
    S_RND  = 11'b00000010000,
    S_WRA  = 11'b00000100000,
    S_WRB  = 11'b00001000000,
    S_ORD  = 11'b00010000000,
    S_OSQ  = 11'b00100000000,
    S_OSUM = 11'b01000000000,
    S_OWT  = 11'b10000000000
  } state_e;

  state_e                  st_q, st_d;
  logic [SW-1:0]           s_q, s_d;
  logic [NW-1:0]           n_q, n_d;
  logic [LOG_POINTS-1:0]   k_q, k_d;
  logic                    ov_q, ov_d;

  logic [WordW-1:0]        b_q, a_q;
  logic signed [ProdW-1:0] m_rr_q, m_ii_q, m_ri_q, m_ir_q;
  logic signed [RndW-1:0]  pr_q, pi_q;
  logic signed [PowerW-1:0] sq_re_q, sq_im_q;
  logic signed [DataW-1:0] re_q, im_q, ore_q, oim_q;
  logic [PowerW-1:0]       opw_q;
  logic [AddrW-1:0]        obin_q;
  logic                    olast_q;

  logic [LOG_POINTS-1:0]   n_ext, mask, lo, a_addr, b_addr;
  logic [AddrW-1:0]        j6;
  logic [RomIdxW-1:0]      ri;
  logic [2*TwW-1:0]        w;
  logic signed [TwW-1:0]   wr, wi;
  logic signed [DataW-1:0] br, bi, ar, ai, rre, rim;
  logic signed [ProdW:0]   sum_r, sum_i;

  always_comb begin
    n_ext  = LOG_POINTS'(n_q);
    mask   = (LOG_POINTS'(1) << s_q) - 1'b1;
    lo     = n_ext & mask;
    a_addr = ((n_ext & ~mask) << 1) | lo;
    b_addr = a_addr | (LOG_POINTS'(1) << s_q);
    j6     = AddrW'(lo);
    ri     = RomIdxW'(j6 << (3'd5 - 3'(s_q)));
    w      = twiddle(ri);
    wr     = w[2*TwW-1:TwW];
    wi     = w[TwW-1:0];
    br     = b_q[WordW-1:DataW];
    bi     = b_q[DataW-1:0];
    ar     = a_q[WordW-1:DataW];
    ai     = a_q[DataW-1:0];
    rre    = ram_rdata_i[WordW-1:DataW];
    rim    = ram_rdata_i[DataW-1:0];
    sum_r  = (ProdW+1)'(m_rr_q) - (ProdW+1)'(m_ii_q) + (ProdW+1)'(16384);
    sum_i  = (ProdW+1)'(m_ri_q) + (ProdW+1)'(m_ir_q) + (ProdW+1)'(16384);
  end

  always_comb begin
    st_d      = st_q;
    s_d       = s_q;
    n_d       = n_q;
    k_d       = k_q;
    ov_d      = ov_q;
    q_pop_o   = 1'b0;
    ram_req_o = '0;
    case (st_q)
      S_LOAD: begin
        q_pop_o         = q_valid_i;
        ram_req_o.we    = q_valid_i;
        ram_req_o.waddr = q_data_i.addr;
        ram_req_o.wdata = {DataW'(q_data_i.sample), {DataW{1'b0}}};
        if (q_valid_i && q_data_i.last) begin
          s_d  = '0;
          n_d  = '0;
          st_d = S_RDB;
        end
      end
      S_RDB: begin
        ram_req_o.raddr = AddrW'(b_addr);
        st_d = S_RDA;
      end
      S_RDA: begin
        ram_req_o.raddr = AddrW'(a_addr);
        st_d = S_MUL;
      end
      S_MUL: st_d = S_RND;
      S_RND: st_d = S_WRA;
      S_WRA: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = AddrW'(a_addr);
        ram_req_o.wdata = {sat24(SumW'(ar) + SumW'(pr_q)), sat24(SumW'(ai) + SumW'(pi_q))};
        st_d = S_WRB;
      end
      S_WRB: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = AddrW'(b_addr);
        ram_req_o.wdata = {sat24(SumW'(ar) - SumW'(pr_q)), sat24(SumW'(ai) - SumW'(pi_q))};
        st_d = S_RDB;
        if (n_q == NW'(Half - 1)) begin
          n_d = '0;
          if (s_q == SW'(LOG_POINTS - 1)) begin
            s_d  = '0;
            k_d  = '0;
            st_d = S_ORD;
          end else begin
            s_d = s_q + 1'b1;
          end
        end else begin
          n_d = n_q + 1'b1;
        end
      end
      S_ORD: begin
        ram_req_o.raddr = AddrW'(k_q);
        st_d = S_OSQ;
      end
      S_OSQ: st_d = S_OSUM;
      S_OSUM: begin
        ov_d = 1'b1;
        st_d = S_OWT;
      end
      S_OWT: begin
        if (result_o.ready) begin
          ov_d = 1'b0;
          if (k_q == LOG_POINTS'(Points - 1)) begin
            st_d = S_LOAD;
          end else begin
            k_d  = k_q + 1'b1;
            st_d = S_ORD;
          end
        end
      end
      default: st_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_RDA) b_q <= ram_rdata_i;
    if (st_q == S_MUL) begin
      a_q    <= ram_rdata_i;
      m_rr_q <= br * wr;
      m_ii_q <= bi * wi;
      m_ri_q <= br * wi;
      m_ir_q <= bi * wr;
    end
    if (st_q == S_RND) begin
      pr_q <= sum_r[ProdW:15];
      pi_q <= sum_i[ProdW:15];
    end
    if (st_q == S_OSQ) begin
      re_q    <= rre;
      im_q    <= rim;
      sq_re_q <= rre * rre;
      sq_im_q <= rim * rim;
    end
    if (st_q == S_OSUM) begin
      ore_q   <= re_q;
      oim_q   <= im_q;
      opw_q   <= PowerW'(sq_re_q) + PowerW'(sq_im_q);
      obin_q  <= AddrW'(k_q);
      olast_q <= (k_q == LOG_POINTS'(Points - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD;
      s_q  <= '0;
      n_q  <= '0;
      k_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      s_q  <= s_d;
      n_q  <= n_d;
      k_q  <= k_d;
      ov_q <= ov_d;
    end
  end

  assign result_o.valid     = ov_q;
  assign result_o.bin_index = obin_q;
  assign result_o.real_part = ore_q;
  assign result_o.imag_part = oim_q;
  assign result_o.power     = opw_q;
  assign result_o.last_bin  = olast_q;
endmodule
`default_nettype wire

### rtl/inplace_radix2_fft_power_core.sv
// radix-2 fft with power output
// sample_i: one signed 16-bit real sample per beat, valid/ready handshake
// result_o: one beat per frequency bin in bin order, with bin_index,
//   real_part, imag_part, power and last_bin set on the final bin
// a frame is 2**LOG_POINTS samples; loading takes one sample per cycle
//   while sample_i.valid is high; once the last sample is in, the
//   transform runs LOG_POINTS stages of 2**(LOG_POINTS-1) butterflies,
//   one at a time on the single read port of the sample memory, each
//   stepping through read b, read a, multiply, round, write a, write b
// each bin then steps through read, square, sum and a wait for ready,
//   so a receiver stall holds back the next bin
// a two-entry queue takes up to two samples while the transform and
//   output run, then sample_i.ready drops until the next frame starts loading
// result_o holds its beat stable while ready is low and the block waits
// reset empties the queue and restarts the frame count; no memory sweep
`default_nettype none
module inplace_radix2_fft_power_core import fftp_pkg::*; #(
  parameter int unsigned LOG_POINTS = LogPointsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fftp_sample_if.sink sample_i,
  fftp_bin_if.source  result_o
);
  localparam int unsigned Points = 1 << LOG_POINTS;

  logic             push_valid, push_ready, pop_valid, pop;
  qent_t            push_data, pop_data;
  ram_req_t         ram_req;
  logic [WordW-1:0] ram_rdata;

  fftp_front #(.LOG_POINTS(LOG_POINTS)) u_front (
    .clk_i, .rst_ni, .sample_i,
    .push_valid_o(push_valid), .push_data_o(push_data), .push_ready_i(push_ready)
  );

  fftp_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_data_i(push_data), .push_ready_o(push_ready),
    .pop_valid_o(pop_valid), .pop_data_o(pop_data), .pop_i(pop)
  );

  fftp_back #(.LOG_POINTS(LOG_POINTS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(pop_valid), .q_data_i(pop_data), .q_pop_o(pop),
    .ram_req_o(ram_req), .ram_rdata_i(ram_rdata), .result_o
  );

  fftp_ram #(.Width(WordW), .Depth(Points)) u_ram (
    .clk_i,
    .we_i(ram_req.we),
    .waddr_i(ram_req.waddr[LOG_POINTS-1:0]),
    .wdata_i(ram_req.wdata),
    .raddr_i(ram_req.raddr[LOG_POINTS-1:0]),
    .rdata_o(ram_rdata)
  );
endmodule
`default_nettype wire

### rtl/fftp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module fftp_checker import fftp_pkg::*; #(
  parameter int unsigned LOG_POINTS = LogPointsDef
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    valid_i,
  input wire logic                    ready_i,
  input wire logic [AddrW-1:0]        bin_i,
  input wire logic signed [DataW-1:0] re_i,
  input wire logic signed [DataW-1:0] im_i,
  input wire logic [PowerW-1:0]       pw_i,
  input wire logic                    last_i
);
  localparam int unsigned Points = 1 << LOG_POINTS;

  logic signed [PowerW-1:0] sq_re, sq_im;
  logic [PowerW-1:0]        pw_chk;
  logic                     is_last;

  assign sq_re   = re_i * re_i;
  assign sq_im   = im_i * im_i;
  assign pw_chk  = PowerW'(sq_re) + PowerW'(sq_im);
  assign is_last = (bin_i == AddrW'(Points - 1));

  `FFTP_ASSERT(a_hold_valid, valid_i && !ready_i |=> valid_i)
  `FFTP_ASSERT(a_hold_bin, valid_i && !ready_i |=> $stable(bin_i) && $stable(re_i))
  `FFTP_ASSERT(a_power, valid_i |-> pw_i == pw_chk)
  `FFTP_ASSERT(a_last, valid_i |-> last_i == is_last)
endmodule

bind inplace_radix2_fft_power_core fftp_checker #(.LOG_POINTS(LOG_POINTS)) u_fftp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .valid_i(result_o.valid), .ready_i(result_o.ready),
  .bin_i(result_o.bin_index), .re_i(result_o.real_part), .im_i(result_o.imag_part),
  .pw_i(result_o.power), .last_i(result_o.last_bin)
);
`default_nettype wire
